// ----- hw/rtl/asl_pkg.sv -----
// Shared types and constants for the stereo stutter loop.
// No dependencies.
package asl_pkg;

	localparam int BUFFER_SAMPLES_DEF = 8192;

	localparam logic [14:0] DEPTH_SMOOTH_RST = 15'd64;
	localparam logic [14:0] RATE_SMOOTH_RST  = 15'd32;
	localparam logic [14:0] Q15_ONE          = 15'd32767;
	localparam logic [14:0] BYPASS_DEPTH     = 15'd32;
	localparam logic [14:0] PRESS_SILENT     = 15'd328;
	localparam logic [18:0] RATE_UNITY       = 19'd65536;
	localparam logic [18:0] RATE_MIN         = 19'd16384;
	localparam logic [18:0] RATE_MAX         = 19'd262144;
	localparam logic [17:0] DEPTH_GAIN       = 18'd163835;
	localparam logic [19:0] RATE_OFFSET      = 20'd262144;
	// ceil(2^21 / 3): exact floor division by three below 2^21
	localparam logic [19:0] RECIP3           = 20'd699051;
	localparam int          RECIP3_SHIFT     = 21;
	localparam int          MIN_LOOP         = 64;

	typedef enum logic [2:0] {
		OP_SAMPLE   = 3'd0,
		OP_GATE_ON  = 3'd1,
		OP_GATE_REP = 3'd2,
		OP_GATE_OFF = 3'd3,
		OP_DEPTH    = 3'd4,
		OP_PRESSURE = 3'd5,
		OP_RATE     = 3'd6
	} op_t;

	typedef enum logic {
		REG_DEPTH_SMOOTH = 1'b0,
		REG_RATE_SMOOTH  = 1'b1
	} reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_SMOOTH,
		ST_RD0,
		ST_RD1,
		ST_INTERP,
		ST_MIX
	} state_t;

endpackage

// ----- hw/rtl/audio_stutter_loop.sv -----
// Stereo stutter loop effect, top level.
// Depends on asl_pkg, asl_ram, asl_div.
//
// Every audio request (operation 0) is captured into a circular stereo store of
// BUFFER_SAMPLES entries and answered by exactly one output sample; control
// requests (gate on/repeat/off, depth, pressure, rate) give no output. Gate on
// and repeat freeze a loop ending at the write point; it is played back at a
// Q16 rate with linear interpolation and crossfaded with the dry input by the
// smoothed depth, saturating to 16 bits. With the gate off and depth below 32
// the input passes through unchanged (wet_active low). An audio request steps
// through the store write, two reads of the single-read-port store, then
// interpolation and mix, skipping the reads and interpolation when bypassed;
// gate repeat waits for the bit-serial loop-length divider; other control
// requests are applied on acceptance. A finished sample waits in the output
// register while the next request is accepted. After reset the store is zeroed
// entry by entry, during which in_ready stays low; configuration writes are
// taken at any time, and should be made only while idle.
module audio_stutter_loop #(
	parameter int BUFFER_SAMPLES = asl_pkg::BUFFER_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	input  logic [15:0]        divisor,
	input  logic [14:0]        depth_q15,
	input  logic [14:0]        pressure_q15,
	input  logic [18:0]        rate_q16,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic               wet_active,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [14:0]        cfg_data
);

	localparam int AW = $clog2(BUFFER_SAMPLES);      // store address
	localparam int LW = $clog2(BUFFER_SAMPLES + 1);  // loop length
	localparam int IW = $clog2(2 * BUFFER_SAMPLES);  // integer part of read position
	localparam int PW = IW + 16;                     // Q16 read position
	localparam logic [LW-1:0] FULL_LEN = LW'(BUFFER_SAMPLES);
	localparam logic [LW-1:0] MIN_LEN  = LW'(asl_pkg::MIN_LOOP);
	localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_SAMPLES - 1);

	asl_pkg::state_t state_q, state_d;

	// control state
	logic [AW-1:0] clr_q;
	logic [AW-1:0] wi_q;
	logic [PW-1:0] pos_q;
	logic [AW-1:0] lb_q;
	logic [LW-1:0] len_q;
	logic [14:0]   dt_q, dc_q;
	logic [18:0]   rt_q, rc_q;
	logic          gate_q;
	logic [14:0]   ds_q, rs_q;
	logic          bypass_q;

	// per-sample payload
	logic signed [15:0] l_q, r_q;
	logic [AW-1:0]      i0_q, i1_q;
	logic [14:0]        frac_q;
	logic signed [15:0] s0l_q, s0r_q;
	logic signed [15:0] loopl_q, loopr_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] lo_q, ro_q;
	logic               wet_q;

	// store and divider hookup
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;
	logic          div_start, div_done;
	logic [LW-1:0] div_quo;
	logic [15:0]   div_den;

	logic accept;
	logic out_free;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// ---------------- smoothing (one-pole, floored Q15 step)
	logic signed [15:0] d_diff;
	logic signed [31:0] d_prod;
	logic signed [16:0] d_step;
	logic [14:0]        dc_new;
	logic signed [19:0] r_diff;
	logic signed [35:0] r_prod;
	logic signed [20:0] r_step;
	logic [18:0]        rc_new;
	logic               bypass_now;

	assign d_diff = $signed({1'b0, dt_q}) - $signed({1'b0, dc_q});
	assign d_prod = d_diff * $signed({1'b0, ds_q});
	assign d_step = 17'(d_prod >>> 15);
	assign dc_new = 15'($signed({2'b0, dc_q}) + d_step);
	assign r_diff = $signed({1'b0, rt_q}) - $signed({1'b0, rc_q});
	assign r_prod = r_diff * $signed({1'b0, rs_q});
	assign r_step = 21'(r_prod >>> 15);
	assign rc_new = 19'($signed({2'b0, rc_q}) + r_step);
	assign bypass_now = !gate_q && (dc_new < asl_pkg::BYPASS_DEPTH);

	// ---------------- read indices from the current position
	logic [IW-1:0] ipos;
	logic [AW-1:0] i0_c, i1_c, wi_next;
	assign ipos    = pos_q[PW-1:16];
	assign i0_c    = (ipos >= IW'(BUFFER_SAMPLES)) ? AW'(ipos - IW'(BUFFER_SAMPLES))
	                                               : AW'(ipos);
	assign i1_c    = (i0_c == LAST_IDX) ? '0 : i0_c + 1'b1;
	assign wi_next = (wi_q == LAST_IDX) ? '0 : wi_q + 1'b1;

	// ---------------- interpolation and position advance
	logic [14:0]        inv_c;
	logic signed [15:0] s1l, s1r;
	logic signed [32:0] il_sum, ir_sum;
	logic [PW:0]        pos_sum;
	logic [IW-1:0]      end_i;
	logic [PW-1:0]      pos_new;
	assign inv_c   = asl_pkg::Q15_ONE - frac_q;
	assign s1l     = $signed(ram_rdata[31:16]);
	assign s1r     = $signed(ram_rdata[15:0]);
	assign il_sum  = s0l_q * $signed({1'b0, inv_c}) + s1l * $signed({1'b0, frac_q});
	assign ir_sum  = s0r_q * $signed({1'b0, inv_c}) + s1r * $signed({1'b0, frac_q});
	assign pos_sum = {1'b0, pos_q} + (PW + 1)'(rc_q);
	assign end_i   = IW'(lb_q) + IW'(len_q);
	assign pos_new = (pos_sum >= {1'b0, end_i, 16'h0}) ? PW'({lb_q, 16'h0})
	                                                   : pos_sum[PW-1:0];

	// ---------------- crossfade
	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

	logic [14:0]        dry_c;
	logic signed [32:0] ml_sum, mr_sum;
	logic signed [15:0] mix_l, mix_r;
	assign dry_c  = asl_pkg::Q15_ONE - dc_q;
	assign ml_sum = l_q * $signed({1'b0, dry_c}) + loopl_q * $signed({1'b0, dc_q});
	assign mr_sum = r_q * $signed({1'b0, dry_c}) + loopr_q * $signed({1'b0, dc_q});
	assign mix_l  = sat16(18'(ml_sum >>> 15));
	assign mix_r  = sat16(18'(mr_sum >>> 15));

	// ---------------- loop freeze (full store, or divided length)
	logic [LW-1:0] frz_len;
	logic [LW:0]   frz_sum;
	logic [AW-1:0] frz_lb;
	assign frz_len = (state_q == asl_pkg::ST_DIV) ?
	                 ((div_quo < MIN_LEN) ? MIN_LEN : div_quo) : FULL_LEN;
	assign frz_sum = (LW + 1)'(wi_q) + (LW + 1)'(BUFFER_SAMPLES) - (LW + 1)'(frz_len);
	assign frz_lb  = (frz_sum >= (LW + 1)'(BUFFER_SAMPLES)) ?
	                 AW'(frz_sum - (LW + 1)'(BUFFER_SAMPLES)) : AW'(frz_sum);

	// ---------------- pressure mapping
	logic [32:0] p_mul;
	logic [16:0] p_d;
	logic [14:0] p_depth;
	logic [17:0] five_x;
	logic [19:0] p_v;
	logic [38:0] p_q3;
	logic [18:0] p_rate;
	logic [18:0] p_rate_raw;
	assign p_mul      = 33'(pressure_q15) * 33'(asl_pkg::DEPTH_GAIN);
	assign p_d        = p_mul[32:16];
	assign p_depth    = (p_d > 17'(asl_pkg::Q15_ONE)) ? asl_pkg::Q15_ONE : p_d[14:0];
	assign five_x     = 18'(pressure_q15) * 18'd5;
	assign p_v        = 20'(pressure_q15) * 20'd20 - asl_pkg::RATE_OFFSET;
	assign p_q3       = 39'(p_v[18:0]) * 39'(asl_pkg::RECIP3);
	assign p_rate_raw = asl_pkg::RATE_UNITY + 19'(p_q3 >> asl_pkg::RECIP3_SHIFT);
	assign p_rate     = (p_rate_raw > asl_pkg::RATE_MAX) ? asl_pkg::RATE_MAX : p_rate_raw;

	logic [18:0] rate_clamped;
	assign rate_clamped = (rate_q16 < asl_pkg::RATE_MIN) ? asl_pkg::RATE_MIN :
	                      (rate_q16 > asl_pkg::RATE_MAX) ? asl_pkg::RATE_MAX : rate_q16;

	// ---------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			asl_pkg::ST_CLEAR: begin
				if (clr_q == LAST_IDX) state_d = asl_pkg::ST_IDLE;
			end
			asl_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == asl_pkg::OP_SAMPLE) state_d = asl_pkg::ST_SMOOTH;
					else if (operation == asl_pkg::OP_GATE_REP) state_d = asl_pkg::ST_DIV;
				end
			end
			asl_pkg::ST_DIV: begin
				if (div_done) state_d = asl_pkg::ST_IDLE;
			end
			asl_pkg::ST_SMOOTH: begin
				state_d = bypass_now ? asl_pkg::ST_MIX : asl_pkg::ST_RD0;
			end
			asl_pkg::ST_RD0:    state_d = asl_pkg::ST_RD1;
			asl_pkg::ST_RD1:    state_d = asl_pkg::ST_INTERP;
			asl_pkg::ST_INTERP: state_d = asl_pkg::ST_MIX;
			asl_pkg::ST_MIX: begin
				if (out_free) state_d = asl_pkg::ST_IDLE;
			end
			default: state_d = asl_pkg::ST_IDLE;
		endcase
	end

	// ---------------- state outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = wi_q;
		ram_wdata = {l_q, r_q};
		ram_raddr = i1_q;
		div_start = 1'b0;
		case (state_q)
			asl_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			asl_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid && (operation == asl_pkg::OP_GATE_REP);
			end
			asl_pkg::ST_SMOOTH: ram_we = 1'b1;
			asl_pkg::ST_RD0:    ram_raddr = i0_q;
			default: ;
		endcase
	end

	assign div_den = (divisor == 16'd0) ? 16'd1 : divisor;

	// ---------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= asl_pkg::ST_CLEAR;
			clr_q       <= '0;
			wi_q        <= '0;
			pos_q       <= '0;
			lb_q        <= '0;
			len_q       <= FULL_LEN;
			dt_q        <= '0;
			dc_q        <= '0;
			rt_q        <= asl_pkg::RATE_UNITY;
			rc_q        <= asl_pkg::RATE_UNITY;
			gate_q      <= 1'b0;
			ds_q        <= asl_pkg::DEPTH_SMOOTH_RST;
			rs_q        <= asl_pkg::RATE_SMOOTH_RST;
			bypass_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				if (cfg_index == asl_pkg::REG_DEPTH_SMOOTH) ds_q <= cfg_data;
				else rs_q <= cfg_data;
			end

			if (state_q == asl_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;

			if (accept) begin
				case (operation)
					asl_pkg::OP_GATE_ON: begin
						gate_q <= 1'b1;
						len_q  <= frz_len;
						lb_q   <= frz_lb;
						pos_q  <= PW'({frz_lb, 16'h0});
						if (dt_q < asl_pkg::PRESS_SILENT) dt_q <= asl_pkg::Q15_ONE;
					end
					asl_pkg::OP_GATE_OFF: begin
						gate_q <= 1'b0;
						dt_q   <= '0;
					end
					asl_pkg::OP_DEPTH: dt_q <= depth_q15;
					asl_pkg::OP_PRESSURE: begin
						if (pressure_q15 < asl_pkg::PRESS_SILENT) begin
							dt_q <= '0;
							rt_q <= asl_pkg::RATE_UNITY;
						end else if (five_x[17:16] == 2'b00) begin
							dt_q <= p_depth;
							rt_q <= asl_pkg::RATE_UNITY;
						end else begin
							dt_q <= asl_pkg::Q15_ONE;
							rt_q <= p_rate;
						end
					end
					asl_pkg::OP_RATE: rt_q <= rate_clamped;
					default: ;
				endcase
			end

			// gate repeat commits once the loop length is known
			if (state_q == asl_pkg::ST_DIV && div_done) begin
				gate_q <= 1'b1;
				len_q  <= frz_len;
				lb_q   <= frz_lb;
				pos_q  <= PW'({frz_lb, 16'h0});
				dt_q   <= asl_pkg::Q15_ONE;
			end

			if (state_q == asl_pkg::ST_SMOOTH) begin
				wi_q     <= wi_next;
				rc_q     <= rc_new;
				dc_q     <= bypass_now ? '0 : dc_new;
				bypass_q <= bypass_now;
			end

			if (state_q == asl_pkg::ST_INTERP) pos_q <= pos_new;

			if (state_q == asl_pkg::ST_MIX && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// ---------------- payload registers
	always_ff @(posedge clk) begin
		if (accept && operation == asl_pkg::OP_SAMPLE) begin
			l_q <= left_in;
			r_q <= right_in;
		end
		if (state_q == asl_pkg::ST_SMOOTH) begin
			i0_q   <= i0_c;
			i1_q   <= i1_c;
			frac_q <= pos_q[15:1];
		end
		if (state_q == asl_pkg::ST_RD1) begin
			s0l_q <= $signed(ram_rdata[31:16]);
			s0r_q <= $signed(ram_rdata[15:0]);
		end
		if (state_q == asl_pkg::ST_INTERP) begin
			loopl_q <= 16'(il_sum >>> 15);
			loopr_q <= 16'(ir_sum >>> 15);
		end
		if (state_q == asl_pkg::ST_MIX && out_free) begin
			lo_q  <= bypass_q ? l_q : mix_l;
			ro_q  <= bypass_q ? r_q : mix_r;
			wet_q <= !bypass_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign left_out   = lo_q;
	assign right_out  = ro_q;
	assign wet_active = wet_q;

	asl_ram #(
		.WIDTH(32),
		.DEPTH(BUFFER_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	asl_div #(
		.DIVIDEND(BUFFER_SAMPLES)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_quo)
	);

	// ---------------- assertions
	a_pos_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < PW'({end_i, 16'h0}))
		else $error("read position outside the frozen loop");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q >= MIN_LEN && len_q <= FULL_LEN)
		else $error("loop length out of range");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == asl_pkg::ST_DIV)
		else $error("divider finished outside gate repeat");

	a_out_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == asl_pkg::ST_MIX)
		else $error("output raised outside the mix step");

endmodule

// ----- hw/rtl/asl_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module asl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/asl_div.sv -----
// Restoring divider: constant dividend over a 16-bit divisor, one quotient bit per cycle.
// No dependencies.
module asl_div #(
	parameter int DIVIDEND = 8192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [15:0]                 divisor,
	output logic                        done,
	output logic [$clog2(DIVIDEND+1)-1:0] quotient
);

	localparam int QW = $clog2(DIVIDEND + 1);
	localparam int CW = $clog2(QW);
	localparam logic [QW-1:0] NUM = QW'(DIVIDEND);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   den_q;
	logic [15:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] bit_idx;
	logic [16:0]   trial;
	logic          fits;

	assign bit_idx = CW'(QW - 1) - cnt_q;
	assign trial   = {rem_q, NUM[bit_idx]};
	assign fits    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule
